>>> rtl/motor_inertia_observer_top_assert.svh
// ----------------------------------------------------------------------------
// motor inertia observer assertion macros
// shared assertion wrappers for the observer rtl
// ----------------------------------------------------------------------------
`ifndef MOTOR_INERTIA_OBSERVER_TOP_ASSERT_SVH
`define MOTOR_INERTIA_OBSERVER_TOP_ASSERT_SVH

// check sampled on the clock, off while reset is held
`define MIO_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is held
`define MIO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/mio_pkg.sv
// ----------------------------------------------------------------------------
// motor inertia observer package
// sequencer states, register codes, fixed widths and saturation helpers
// ----------------------------------------------------------------------------
package mio_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GAIN,
    ST_P1,
    ST_P2,
    ST_FLUX,
    ST_NPP,
    ST_WDIV,
    ST_QDOT,
    ST_Q0,
    ST_Q1,
    ST_TAU,
    ST_XPROD,
    ST_XTS,
    ST_EPROD,
    ST_ETS,
    ST_JDIV,
    ST_FIN
  } state_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUX       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TS         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL    = 3'd5;

  localparam int PP_W      = 5;
  localparam int FLUX_W    = 16;
  localparam int LAMBDA_W  = 16;
  localparam int TS_W      = 32;
  localparam int PERIOD_W  = 24;
  localparam int NOM_W     = 24;
  localparam int INERTIA_W = 21;
  localparam int TORQUE_W  = 32;

  localparam logic [PP_W-1:0]     PP_RST      = 5'd2;
  localparam logic [FLUX_W-1:0]   FLUX_RST    = 16'd0;
  localparam logic [LAMBDA_W-1:0] LAMBDA_RST  = 16'd8038;
  localparam logic [TS_W-1:0]     TS_RST      = 32'd429497;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 24'd20000;
  localparam logic [NOM_W-1:0]    NOMINAL_RST = 24'd1677722;

  localparam logic [INERTIA_W-1:0] INERTIA_MIN = 21'd16777;
  localparam logic [INERTIA_W-1:0] INERTIA_MAX = 21'd1677722;
  localparam logic signed [63:0]   SUMB_FLOOR  = 64'sd4294967;

  localparam int FILT_W = 38;
  localparam logic signed [FILT_W-1:0] FILT_LIM = 38'sh1F_FFFF_FFFF;
  localparam int GAIN_W = 25;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 25'h100_0000;

  localparam int MUL_AM_W    = 63;
  localparam int MUL_BM_W    = 32;
  localparam int MUL_DIG_W   = 8;
  localparam int MUL_DIGITS  = 4;
  localparam int MUL_PM_W    = 95;
  localparam int MCNT_W      = 3;

  localparam int SPD_SHIFT = 21;
  localparam int JQ_W      = 27;
  localparam int JDIV_LAST = 26;
  localparam logic [JQ_W-1:0] JQ_SAT = 27'h400_0000;
  localparam int DIV_W     = 66;
  localparam int TERM_W    = 64;

  function automatic logic signed [FILT_W-1:0] sat_filt(input logic signed [95:0] v);
    logic signed [95:0] lim;
    lim = 96'(FILT_LIM);
    if (v > lim) begin
      return FILT_LIM;
    end else if (v < -lim) begin
      return -FILT_LIM;
    end
    return FILT_W'(v);
  endfunction

  function automatic logic signed [31:0] sat_i32(input logic signed [39:0] v);
    if (v > 40'sh00_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_7FFF_FFFF) begin
      return -32'sh7FFF_FFFF;
    end
    return 32'(v);
  endfunction

endpackage

>>> rtl/motor_inertia_observer_top.sv
// sequencing: each sample runs through the multiply and speed divide steps, plus the inertia divide at a window close
// throughput: a new sample is taken only when the sequencer is idle, set by a shared 63x8 multiply
// step (13 products) and a shared compare-subtract divide step (one quotient bit per cycle)
// reset: asynchronous, active low; registers to their documented values, filters and sums to
// zero, inertia to the maximum 1677722, no result pending
// ----------------------------------------------------------------------------
// motor inertia observer
// torque and speed filters, disturbance torque and windowed inertia update
// ----------------------------------------------------------------------------
`include "motor_inertia_observer_top_assert.svh"

module motor_inertia_observer_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [mio_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [mio_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]        current_alpha_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        current_beta_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        angle_cos_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        angle_sin_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        rotor_speed_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mio_pkg::INERTIA_W-1:0]         inertia_estimate_o,
  output logic signed [mio_pkg::TORQUE_W-1:0]   disturbance_torque_o,
  output logic                                  window_done_o
);
  import mio_pkg::*;

  localparam int DVD_W  = SAMPLE_WIDTH + SPD_SHIFT;
  localparam int DQ_W   = (DVD_W > JQ_W) ? DVD_W : JQ_W;
  localparam int DCNT_W = $clog2(DQ_W) + 1;
  localparam int SUM_W  = TERM_W + 2;
  localparam logic signed [SUM_W-1:0] ACC_LIM =
    {{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};

  function automatic logic signed [ACC_WIDTH-1:0] acc_add(
    input logic signed [ACC_WIDTH-1:0] a,
    input logic signed [TERM_W-1:0]    t
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(t);
    if (s > ACC_LIM) begin
      return ACC_WIDTH'(ACC_LIM);
    end else if (s < -ACC_LIM) begin
      return ACC_WIDTH'(-ACC_LIM);
    end
    return ACC_WIDTH'(s);
  endfunction

  state_e state_q, state_d;

  logic [PP_W-1:0]     pp_q;
  logic [FLUX_W-1:0]   flux_q;
  logic [LAMBDA_W-1:0] lambda_q;
  logic [TS_W-1:0]     ts_q;
  logic [PERIOD_W-1:0] period_q;
  logic [NOM_W-1:0]    nominal_q;

  logic signed [SAMPLE_WIDTH-1:0] ia_q, ib_q, c_q, s_q, spd_q;

  logic [GAIN_W-1:0]          g_q;
  logic signed [63:0]         x_q;
  logic signed [FILT_W-1:0]   trq_q, w_q, q0_q, q1_q;
  logic signed [FILT_W:0]     qdot_q;
  logic signed [31:0]         tau_q;
  logic signed [ACC_WIDTH-1:0] cross_q, energy_q;
  logic [PERIOD_W-1:0]        wcnt_q;
  logic [INERTIA_W-1:0]       inertia_q;
  logic                       done_q;

  logic [MCNT_W-1:0]   mcnt_q;
  logic [MUL_AM_W-1:0] am_q;
  logic [MUL_BM_W-1:0] bm_q;
  logic                neg_q;
  logic [MUL_PM_W-1:0] macc_q;

  logic [DCNT_W-1:0] dcnt_q;
  logic [DIV_W-1:0]  r_q;
  logic [63:0]       ub_q;
  logic [DVD_W-1:0]  dvd_q;
  logic [DQ_W-1:0]   dq_q;
  logic              dneg_q;

  logic                        out_valid_q;
  logic [INERTIA_W-1:0]        out_inertia_q;
  logic signed [TORQUE_W-1:0]  out_torque_q;
  logic                        out_done_q;

  // shared multiply unit
  logic                        mul_state, mul_last, mul_load;
  logic signed [63:0]          a_s;
  logic signed [MUL_BM_W:0]    b_s;
  logic [MUL_AM_W-1:0]         am_d;
  logic [MUL_BM_W-1:0]         bm_d;
  logic [MUL_AM_W+MUL_DIG_W-1:0] pp_digit;
  logic [MUL_PM_W-1:0]         macc_nx;
  logic signed [MUL_PM_W:0]    mag_ext, prod_s;
  logic [MUL_PM_W-33:0]        mag_hi;
  logic signed [TERM_W-1:0]    term;

  logic [PP_W-1:0]             npp;
  logic signed [FILT_W:0]      ew, et;
  logic signed [31:0]          qd32;
  logic signed [39:0]          tau_full;
  logic [31:0]                 g_raw;
  logic signed [ACC_WIDTH-1:0] cross_nx, energy_nx;
  logic signed [63:0]          energy_ext;
  logic [ACC_WIDTH-1:0]        cabs;
  logic                        close;
  logic [SAMPLE_WIDTH-1:0]     spd_mag;

  // shared divide unit
  logic [DIV_W-1:0] rr, dv, r_nx;
  logic             dbit;
  logic [DQ_W-1:0]  dq_nx;
  logic             wdiv_last, jdiv_sat, jdiv_last;
  logic signed [DQ_W:0] wq_s;
  logic [JQ_W-1:0]  jq;
  logic signed [JQ_W:0] jv;
  logic [INERTIA_W-1:0] j_clamped;

  logic fin_load, in_acc, cfg_acc;

  assign npp = (pp_q == '0) ? PP_W'(1) : pp_q;
  assign ew  = (FILT_W+1)'(w_q) - (FILT_W+1)'(q1_q);
  assign et  = (FILT_W+1)'(trq_q) - (FILT_W+1)'(q0_q);
  assign qd32 = sat_i32(40'(qdot_q));

  always_comb begin
    mul_state = 1'b0;
    a_s = '0;
    b_s = '0;
    unique case (state_q)
      ST_GAIN: begin
        mul_state = 1'b1;
        a_s = 64'(ts_q);
        b_s = (MUL_BM_W+1)'(lambda_q);
      end
      ST_P1: begin
        mul_state = 1'b1;
        a_s = 64'(ib_q);
        b_s = (MUL_BM_W+1)'(c_q);
      end
      ST_P2: begin
        mul_state = 1'b1;
        a_s = 64'(ia_q);
        b_s = (MUL_BM_W+1)'(s_q);
      end
      ST_FLUX: begin
        mul_state = 1'b1;
        a_s = x_q;
        b_s = (MUL_BM_W+1)'(flux_q);
      end
      ST_NPP: begin
        mul_state = 1'b1;
        a_s = x_q;
        b_s = (MUL_BM_W+1)'(npp);
      end
      ST_QDOT: begin
        mul_state = 1'b1;
        a_s = 64'(ew);
        b_s = (MUL_BM_W+1)'(lambda_q);
      end
      ST_Q0: begin
        mul_state = 1'b1;
        a_s = 64'(et);
        b_s = (MUL_BM_W+1)'(g_q);
      end
      ST_Q1: begin
        mul_state = 1'b1;
        a_s = 64'(ew);
        b_s = (MUL_BM_W+1)'(g_q);
      end
      ST_TAU: begin
        mul_state = 1'b1;
        a_s = 64'(qdot_q);
        b_s = (MUL_BM_W+1)'(nominal_q);
      end
      ST_XPROD: begin
        mul_state = 1'b1;
        a_s = 64'(tau_q);
        b_s = (MUL_BM_W+1)'(qd32);
      end
      ST_XTS, ST_ETS: begin
        mul_state = 1'b1;
        a_s = x_q;
        b_s = (MUL_BM_W+1)'(ts_q);
      end
      ST_EPROD: begin
        mul_state = 1'b1;
        a_s = 64'(qd32);
        b_s = (MUL_BM_W+1)'(qd32);
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
  end

  assign am_d     = a_s[63] ? MUL_AM_W'(-a_s) : MUL_AM_W'(a_s);
  assign bm_d     = b_s[MUL_BM_W] ? MUL_BM_W'(-b_s) : MUL_BM_W'(b_s);
  assign mul_load = mul_state && (mcnt_q == '0);
  assign mul_last = mul_state && (mcnt_q == MCNT_W'(MUL_DIGITS));
  assign pp_digit = am_q * bm_q[MUL_BM_W-1 -: MUL_DIG_W];
  assign macc_nx  = {macc_q[MUL_PM_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}}
                  + MUL_PM_W'(pp_digit);
  assign mag_ext  = {1'b0, macc_nx};
  assign prod_s   = neg_q ? -mag_ext : mag_ext;
  assign mag_hi   = macc_nx[MUL_PM_W-1:32];
  assign term     = neg_q ? -$signed({1'b0, mag_hi}) : $signed({1'b0, mag_hi});

  assign g_raw    = macc_nx[47:16];
  assign tau_full = 40'(q0_q >>> 8) - 40'(prod_s >>> 24);
  assign cross_nx  = acc_add(cross_q, term);
  assign energy_nx = acc_add(energy_q, term);
  assign energy_ext = 64'(energy_nx);
  assign cabs     = cross_q[ACC_WIDTH-1] ? ACC_WIDTH'(-cross_q) : ACC_WIDTH'(cross_q);
  assign close    = ((PERIOD_W+1)'(wcnt_q) + (PERIOD_W+1)'(1)) >= (PERIOD_W+1)'(period_q);
  assign spd_mag  = spd_q[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-spd_q) : SAMPLE_WIDTH'(spd_q);

  always_comb begin
    rr = r_q;
    dv = DIV_W'(ub_q);
    if (state_q == ST_WDIV) begin
      rr = {r_q[DIV_W-2:0], dvd_q[DVD_W-1]};
      dv = DIV_W'(npp);
    end else if (dcnt_q == '0) begin
      dv = {ub_q, 2'b00};
    end else if (dcnt_q == DCNT_W'(1)) begin
      dv = {1'b0, ub_q, 1'b0};
    end else if (dcnt_q == DCNT_W'(2)) begin
      dv = DIV_W'(ub_q);
    end else begin
      rr = {r_q[DIV_W-2:0], 1'b0};
    end
  end

  assign dbit  = rr >= dv;
  assign r_nx  = dbit ? (rr - dv) : rr;
  assign dq_nx = {dq_q[DQ_W-2:0], dbit};
  assign wdiv_last = (state_q == ST_WDIV) && (dcnt_q == DCNT_W'(DVD_W - 1));
  assign jdiv_sat  = (state_q == ST_JDIV) && (dcnt_q == '0) && dbit;
  assign jdiv_last = (state_q == ST_JDIV) && (dcnt_q == DCNT_W'(JDIV_LAST));
  assign wq_s = dneg_q ? -$signed({1'b0, dq_nx}) : $signed({1'b0, dq_nx});
  assign jq   = jdiv_sat ? JQ_SAT : dq_nx[JQ_W-1:0];
  assign jv   = (JQ_W+1)'(nominal_q)
              + (dneg_q ? -$signed({1'b0, jq}) : $signed({1'b0, jq}));
  always_comb begin
    if (jv > $signed((JQ_W+1)'(INERTIA_MAX))) begin
      j_clamped = INERTIA_MAX;
    end else if (jv < $signed((JQ_W+1)'(INERTIA_MIN))) begin
      j_clamped = INERTIA_MIN;
    end else begin
      j_clamped = INERTIA_W'(jv);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_GAIN;
      ST_GAIN:  if (mul_last) state_d = ST_P1;
      ST_P1:    if (mul_last) state_d = ST_P2;
      ST_P2:    if (mul_last) state_d = ST_FLUX;
      ST_FLUX:  if (mul_last) state_d = ST_NPP;
      ST_NPP:   if (mul_last) state_d = ST_WDIV;
      ST_WDIV:  if (wdiv_last) state_d = ST_QDOT;
      ST_QDOT:  if (mul_last) state_d = ST_Q0;
      ST_Q0:    if (mul_last) state_d = ST_Q1;
      ST_Q1:    if (mul_last) state_d = ST_TAU;
      ST_TAU:   if (mul_last) state_d = ST_XPROD;
      ST_XPROD: if (mul_last) state_d = ST_XTS;
      ST_XTS:   if (mul_last) state_d = ST_EPROD;
      ST_EPROD: if (mul_last) state_d = ST_ETS;
      ST_ETS: begin
        if (mul_last) state_d = close ? ST_JDIV : ST_FIN;
      end
      ST_JDIV:  if (jdiv_sat || jdiv_last) state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
    fin_load    = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
    in_acc      = in_valid_i && !in_stall_o;
    cfg_acc     = cfg_valid_i && cfg_ready_o;
  end

  assign inertia_estimate_o   = out_inertia_q;
  assign disturbance_torque_o = out_torque_q;
  assign window_done_o        = out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      pp_q        <= PP_RST;
      flux_q      <= FLUX_RST;
      lambda_q    <= LAMBDA_RST;
      ts_q        <= TS_RST;
      period_q    <= PERIOD_RST;
      nominal_q   <= NOMINAL_RST;
      q0_q        <= '0;
      q1_q        <= '0;
      cross_q     <= '0;
      energy_q    <= '0;
      wcnt_q      <= '0;
      inertia_q   <= INERTIA_MAX;
    end else begin
      state_q <= state_d;

      if (cfg_acc) begin
        unique case (cfg_index_i)
          CFG_POLE_PAIRS: pp_q      <= cfg_data_i[PP_W-1:0];
          CFG_FLUX:       flux_q    <= cfg_data_i[FLUX_W-1:0];
          CFG_LAMBDA:     lambda_q  <= cfg_data_i[LAMBDA_W-1:0];
          CFG_TS:         ts_q      <= cfg_data_i[TS_W-1:0];
          CFG_PERIOD:     period_q  <= cfg_data_i[PERIOD_W-1:0];
          CFG_NOMINAL:    nominal_q <= cfg_data_i[NOM_W-1:0];
          default:        ;
        endcase
      end

      if (mul_state) begin
        mcnt_q <= mul_last ? '0 : mcnt_q + MCNT_W'(1);
      end

      if (state_q == ST_NPP && mul_last) begin
        dcnt_q <= '0;
      end else if (state_q == ST_ETS && mul_last) begin
        dcnt_q <= '0;
      end else if (state_q == ST_WDIV || (state_q == ST_JDIV && !jdiv_sat)) begin
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end

      if (mul_last) begin
        unique case (state_q)
          ST_Q0:  q0_q <= q0_q + FILT_W'(prod_s >>> 24);
          ST_Q1:  q1_q <= q1_q + FILT_W'(prod_s >>> 24);
          ST_XTS: cross_q <= cross_nx;
          ST_ETS: begin
            energy_q <= energy_nx;
            if (!close) wcnt_q <= wcnt_q + PERIOD_W'(1);
          end
          default: ;
        endcase
      end

      if (jdiv_sat || jdiv_last) begin
        inertia_q <= j_clamped;
        cross_q   <= '0;
        energy_q  <= '0;
        wcnt_q    <= '0;
      end

      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ia_q  <= current_alpha_i;
      ib_q  <= current_beta_i;
      c_q   <= angle_cos_i;
      s_q   <= angle_sin_i;
      spd_q <= rotor_speed_i;
    end

    if (mul_load) begin
      am_q   <= am_d;
      bm_q   <= bm_d;
      neg_q  <= a_s[63] ^ b_s[MUL_BM_W];
      macc_q <= '0;
    end else if (mul_state) begin
      macc_q <= macc_nx;
      bm_q   <= {bm_q[MUL_BM_W-MUL_DIG_W-1:0], {MUL_DIG_W{1'b0}}};
    end

    if (mul_last) begin
      unique case (state_q)
        ST_GAIN:  g_q <= (g_raw > 32'(GAIN_ONE)) ? GAIN_ONE : g_raw[GAIN_W-1:0];
        ST_P1:    x_q <= 64'(prod_s);
        ST_P2:    x_q <= x_q - 64'(prod_s);
        ST_FLUX:  x_q <= 64'(prod_s >>> 17);
        ST_NPP: begin
          trq_q  <= sat_filt(96'(prod_s));
          r_q    <= '0;
          dq_q   <= '0;
          dvd_q  <= {spd_mag, {SPD_SHIFT{1'b0}}};
          dneg_q <= spd_q[SAMPLE_WIDTH-1];
        end
        ST_QDOT:  qdot_q <= (FILT_W+1)'(prod_s >>> 16);
        ST_TAU:   tau_q <= sat_i32(tau_full);
        ST_XPROD: x_q <= 64'(prod_s);
        ST_EPROD: x_q <= 64'(prod_s);
        ST_ETS: begin
          done_q <= close;
          r_q    <= DIV_W'(cabs);
          dq_q   <= '0;
          dneg_q <= cross_q[ACC_WIDTH-1];
          ub_q   <= (energy_ext < SUMB_FLOOR) ? SUMB_FLOOR : energy_ext;
        end
        default: ;
      endcase
    end

    if (state_q == ST_WDIV) begin
      r_q   <= r_nx;
      dq_q  <= dq_nx;
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      if (wdiv_last) w_q <= sat_filt(96'(wq_s));
    end else if (state_q == ST_JDIV && dcnt_q != '0) begin
      r_q  <= r_nx;
      dq_q <= dq_nx;
    end

    if (fin_load) begin
      out_inertia_q <= inertia_q;
      out_torque_q  <= tau_q;
      out_done_q    <= done_q;
    end
  end

  `MIO_ASSERT(a_inertia_range, clk_i, rst_ni,
    (inertia_q >= INERTIA_MIN && inertia_q <= INERTIA_MAX), "inertia out of range")
  `MIO_ASSERT(a_mcnt_mul_only, clk_i, rst_ni, (mcnt_q != '0 |-> mul_state),
    "multiply step outside a multiply state")
  `MIO_ASSERT(a_window_clear, clk_i, rst_ni, ((state_q == ST_FIN && done_q) |-> wcnt_q == '0),
    "window closed without clearing its count")
  `MIO_ASSERT(a_gain_max, clk_i, rst_ni,
    ((state_q == ST_Q0 || state_q == ST_Q1) |-> g_q <= GAIN_ONE), "filter gain above one")

endmodule
